// ----- design/hhp_pkg.sv -----
// ----------------------------------------------------------------------------
// Heading hold PID package
// Widths, fixed-point constants, register indexes and the struct shared by
// the heading hold controller.
// ----------------------------------------------------------------------------
package hhp_pkg;

  // Field widths.
  localparam int unsigned HEAD_W    = 13;
  localparam int unsigned ERR_W     = 14;
  localparam int unsigned WRAP_W    = 15;
  localparam int unsigned INTEG_W   = 24;
  localparam int unsigned DERIV_W   = 15;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned CMD_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Product and sum widths (gains enter as signed with a zero sign bit).
  localparam int unsigned PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int unsigned PROD_I_W = GAIN_W + 1 + INTEG_W;
  localparam int unsigned PROD_D_W = GAIN_W + 1 + DERIV_W;
  localparam int unsigned SUM_W    = 42;
  localparam int unsigned FRAC_W   = 12;
  localparam int unsigned QUOT_W   = SUM_W + 1 - FRAC_W;

  // Angles in 1/16 degree.
  localparam logic signed [WRAP_W-1:0] HALF_TURN     = 15'sd2880;
  localparam logic signed [WRAP_W-1:0] NEG_HALF_TURN = -15'sd2880;
  localparam logic signed [WRAP_W-1:0] FULL_TURN     = 15'sd5760;

  // Integral saturation limits, one bit wider than the integral.
  localparam logic signed [INTEG_W:0] INTEG_MAX = 25'sd8388607;
  localparam logic signed [INTEG_W:0] INTEG_MIN = -25'sd8388608;

  // Rounding constant: one half in Q.12.
  localparam logic [SUM_W:0] ROUND_HALF = 43'd2048;

  // Output saturation limits on the rounded magnitude.
  localparam logic [QUOT_W-1:0] MAG_POS_MAX = 31'd32767;
  localparam logic [QUOT_W-1:0] MAG_NEG_MAX = 31'd32768;
  localparam logic signed [CMD_W-1:0] CMD_MAX = 16'sh7FFF;
  localparam logic signed [CMD_W-1:0] CMD_MIN = 16'sh8000;

  // Gain reset values, unsigned Q4.12.
  localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd4096;
  localparam logic [GAIN_W-1:0] GAIN_I_RESET = 16'd61;
  localparam logic [GAIN_W-1:0] GAIN_D_RESET = 16'd819;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 2'd2;

  // Error terms of one tick, handed from the error stage to the multipliers.
  typedef struct packed {
    logic                      hold;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DERIV_W-1:0] deriv;
  } err_word_t;

endpackage

// ----- design/hhp_in_if.sv -----
// ----------------------------------------------------------------------------
// Heading hold input channel
// Valid/ready channel carrying one measured heading word per control tick.
// ----------------------------------------------------------------------------
interface hhp_in_if
  import hhp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [HEAD_W-1:0] measured_heading;
  logic                     rotation_commanded;

  modport source (output valid, measured_heading, rotation_commanded, input ready);
  modport sink   (input valid, measured_heading, rotation_commanded, output ready);
endinterface

// ----- design/hhp_out_if.sv -----
// ----------------------------------------------------------------------------
// Heading hold output channel
// Valid/ready channel carrying one yaw rate command word per control tick.
// ----------------------------------------------------------------------------
interface hhp_out_if
  import hhp_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] yaw_rate_command;
  logic                    hold_active;

  modport source (output valid, yaw_rate_command, hold_active, input ready);
  modport sink   (input valid, yaw_rate_command, hold_active, output ready);
endinterface

// ----- design/hhp_err_state.sv -----
// ----------------------------------------------------------------------------
// Heading hold error stage
// Holds the setpoint, integral and last error, and forms the wrapped error,
// saturated integral and derivative of each accepted word.
// ----------------------------------------------------------------------------
module hhp_err_state
  import hhp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic signed [HEAD_W-1:0] meas_i,
  input  logic                     rot_i,
  output err_word_t                word_o
);

  logic signed [HEAD_W-1:0]  setpoint_q, setpoint_d;
  logic                      captured_q, captured_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [ERR_W-1:0]   prev_q, prev_d;

  logic signed [HEAD_W-1:0]  sp;
  logic signed [WRAP_W-1:0]  raw;
  logic signed [WRAP_W-1:0]  wrapped;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [DERIV_W-1:0] deriv;

  // Error against the held setpoint, or against itself on the capture tick.
  always_comb begin
    sp  = captured_q ? setpoint_q : meas_i;
    raw = WRAP_W'(sp) - WRAP_W'(meas_i);
    if (raw > HALF_TURN) begin
      wrapped = raw - FULL_TURN;
    end else if (raw < NEG_HALF_TURN) begin
      wrapped = raw + FULL_TURN;
    end else begin
      wrapped = raw;
    end
    err = wrapped[ERR_W-1:0];
  end

  // Saturating integral and first difference.
  always_comb begin
    integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err);
    if (integ_sum > INTEG_MAX) begin
      integ_sat = INTEG_MAX[INTEG_W-1:0];
    end else if (integ_sum < INTEG_MIN) begin
      integ_sat = INTEG_MIN[INTEG_W-1:0];
    end else begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end
    deriv = DERIV_W'(err) - DERIV_W'(prev_q);
  end

  // State update: a rotation tick clears the loop, a hold tick advances it.
  always_comb begin
    setpoint_d = setpoint_q;
    captured_d = captured_q;
    integ_d    = integ_q;
    prev_d     = prev_q;
    if (accept_i) begin
      if (rot_i) begin
        captured_d = 1'b0;
        integ_d    = '0;
        prev_d     = '0;
      end else begin
        setpoint_d = sp;
        captured_d = 1'b1;
        integ_d    = integ_sat;
        prev_d     = err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      captured_q <= 1'b0;
      integ_q    <= '0;
      prev_q     <= '0;
    end else begin
      setpoint_q <= setpoint_d;
      captured_q <= captured_d;
      integ_q    <= integ_d;
      prev_q     <= prev_d;
    end
  end

  // Terms for the multipliers; all zero on a rotation tick.
  always_comb begin
    word_o.hold  = !rot_i;
    word_o.err   = rot_i ? '0 : err;
    word_o.integ = rot_i ? '0 : integ_sat;
    word_o.deriv = rot_i ? '0 : deriv;
  end

endmodule

// ----- design/heading_hold_pid.sv -----
// ----------------------------------------------------------------------------
// Heading hold PID controller
// Wrapped heading error, saturating integral and derivative, scaled by Q4.12
// gains; the negated, rounded and saturated sum is the yaw rate command.
// ----------------------------------------------------------------------------
// Path: an accepted input word passes four registers (error terms,
// products, sum, rounded output) on its way to the command word, the first
// of them loaded at the accepting edge.
// Throughput: one word per cycle; each stage advances whenever the stage
// after it is empty or moving, so a stalled output only blocks once full.
// Reset: clears setpoint, capture flag, integral, last error and all stage
// valid bits; the gains return to 1.0, about 0.015 and about 0.2.
module heading_hold_pid
  import hhp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hhp_in_if.sink               in_i,
  hhp_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GAIN_W-1:0]    cfg_wdata_i
);

  logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;

  // Gain registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= GAIN_P_RESET;
      gain_i_q <= GAIN_I_RESET;
      gain_d_q <= GAIN_D_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN_P: gain_p_q <= cfg_wdata_i;
        REG_GAIN_I: gain_i_q <= cfg_wdata_i;
        REG_GAIN_D: gain_d_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake.
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;
  logic in_acc;

  assign s4_rdy     = !s4_v_q || out_o.ready;
  assign s3_rdy     = !s3_v_q || s4_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_i.ready = s1_rdy;
  assign in_acc     = in_i.valid && s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= in_i.valid;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
      if (s4_rdy) s4_v_q <= s3_v_q;
    end
  end

  // Stage 1: error terms and loop state.
  err_word_t s1_d, s1_q;

  hhp_err_state u_err_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .meas_i   (in_i.measured_heading),
    .rot_i    (in_i.rotation_commanded),
    .word_o   (s1_d)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_q <= s1_d;
  end

  // Stage 2: three gain products.
  logic signed [PROD_P_W-1:0] prod_p_q;
  logic signed [PROD_I_W-1:0] prod_i_q;
  logic signed [PROD_D_W-1:0] prod_d_q;
  logic                       s2_hold_q;

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      prod_p_q  <= $signed({1'b0, gain_p_q}) * s1_q.err;
      prod_i_q  <= $signed({1'b0, gain_i_q}) * s1_q.integ;
      prod_d_q  <= $signed({1'b0, gain_d_q}) * s1_q.deriv;
      s2_hold_q <= s1_q.hold;
    end
  end

  // Stage 3: PID sum in Q.12.
  logic signed [SUM_W-1:0] sum_q;
  logic                    s3_hold_q;

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_v_q) begin
      sum_q     <= SUM_W'(prod_p_q) + SUM_W'(prod_i_q) + SUM_W'(prod_d_q);
      s3_hold_q <= s2_hold_q;
    end
  end

  // Stage 4: round half away from zero, negate and saturate.
  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W:0]    rnd;
  logic [QUOT_W-1:0] quot;
  logic [CMD_W-1:0]  cmd_d;
  logic [CMD_W-1:0]  cmd_q;
  logic              s4_hold_q;

  always_comb begin
    neg  = sum_q[SUM_W-1];
    mag  = neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    rnd  = {1'b0, mag} + ROUND_HALF;
    quot = rnd[SUM_W:FRAC_W];
    if (!s3_hold_q) begin
      cmd_d = '0;
    end else if (neg) begin
      // Negative sum gives a positive command.
      cmd_d = (quot > MAG_POS_MAX) ? CMD_MAX : quot[CMD_W-1:0];
    end else begin
      cmd_d = (quot > MAG_NEG_MAX) ? CMD_MIN : CMD_W'(16'd0 - quot[CMD_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_rdy && s3_v_q) begin
      cmd_q     <= cmd_d;
      s4_hold_q <= s3_hold_q;
    end
  end

  assign out_o.valid            = s4_v_q;
  assign out_o.yaw_rate_command = cmd_q;
  assign out_o.hold_active      = s4_hold_q;

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Heading hold PID testbench
// Drives measured heading words with random gaps, stalls the yaw rate
// command channel at random, and checks every command against an in-bench
// model of the hold loop: setpoint capture, angle wrap, saturating integral,
// rounding and output saturation. The run covers reset gains, extreme and
// random gains, and long hold runs with a steady error of either sign.
// ----------------------------------------------------------------------------
module tb_top;
  import hhp_pkg::*;

  // Index past the last gain register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned SWEEP_LEN = 200;
  localparam int unsigned N_DIRECTED = 18;

  typedef struct packed {
    logic signed [CMD_W-1:0] cmd;
    logic                    hold;
  } yaw_word_t;

  typedef struct packed {
    logic signed [HEAD_W-1:0] heading;
    logic                     rotate;
    logic                     typed;
    yaw_word_t                typed_word;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [GAIN_W-1:0]    cfg_wdata;
  logic                 steady;
  int unsigned          mismatches;

  // Model of the controller state and gains.
  logic [GAIN_W-1:0]         m_gain_p;
  logic [GAIN_W-1:0]         m_gain_i;
  logic [GAIN_W-1:0]         m_gain_d;
  logic signed [HEAD_W-1:0]  m_setpoint;
  logic                      m_captured;
  logic signed [INTEG_W-1:0] m_integ;
  logic signed [ERR_W-1:0]   m_prev_err;

  // Commands still owed by the block, oldest first.
  yaw_word_t pending_cmds[$];

  hhp_in_if  in_bus ();
  hhp_out_if out_bus ();

  heading_hold_pid u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Directed words; typed expectations only where the result is obvious.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{13'sd0,     1'b0, 1'b1, '{16'sd0, 1'b1}},  // first hold after reset
    '{13'sd2879,  1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{-13'sd2880, 1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{13'h0FFF,   1'b0, 1'b0, '{16'sd0, 1'b0}},  // pattern past +180
    '{13'h1000,   1'b0, 1'b0, '{16'sd0, 1'b0}},  // pattern past -180
    '{13'sd100,   1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{13'sd100,   1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{-13'sd2000, 1'b0, 1'b1, '{16'sd0, 1'b1}},  // recapture
    '{13'sd2000,  1'b0, 1'b0, '{16'sd0, 1'b0}},  // error wraps up
    '{-13'sd2000, 1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{13'sd880,   1'b0, 1'b0, '{16'sd0, 1'b0}},  // error exactly -180
    '{13'sd881,   1'b0, 1'b0, '{16'sd0, 1'b0}},  // one step past -180
    '{13'h1000,   1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{13'h0FFF,   1'b1, 1'b1, '{16'sd0, 1'b0}},
    '{13'h0FFF,   1'b0, 1'b1, '{16'sd0, 1'b1}},  // capture out of range
    '{13'h1000,   1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{13'sd0,     1'b0, 1'b0, '{16'sd0, 1'b0}},
    '{13'sd0,     1'b1, 1'b1, '{16'sd0, 1'b0}}
  };

  // Clock, period 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One control tick of the hold loop; updates the model state.
  function automatic yaw_word_t pid_tick(input logic signed [HEAD_W-1:0] heading,
                                         input logic rotating);
    yaw_word_t res;
    int        err;
    int        deriv;
    longint    acc;
    longint    pid_sum;
    longint    mag;
    longint    q;
    if (rotating) begin
      m_integ    = '0;
      m_prev_err = '0;
      m_captured = 1'b0;
      res.cmd    = '0;
      res.hold   = 1'b0;
      return res;
    end
    if (!m_captured) begin
      m_setpoint = heading;
      m_captured = 1'b1;
    end
    err = int'(m_setpoint) - int'(heading);
    if (err > HALF_TURN) err -= FULL_TURN;
    if (err < NEG_HALF_TURN) err += FULL_TURN;
    acc = longint'(m_integ) + err;
    if (acc > INTEG_MAX) acc = longint'(INTEG_MAX);
    if (acc < INTEG_MIN) acc = longint'(INTEG_MIN);
    m_integ = acc[INTEG_W-1:0];
    deriv = err - int'(m_prev_err);
    m_prev_err = err[ERR_W-1:0];
    pid_sum = longint'(m_gain_p) * err + longint'(m_gain_i) * acc
            + longint'(m_gain_d) * deriv;
    // Round half away from zero, then negate and saturate.
    mag = (pid_sum < 0) ? -pid_sum : pid_sum;
    q = (mag + 2048) / 4096;
    if (pid_sum < 0) q = -q;
    q = -q;
    if (q > CMD_MAX) q = longint'(CMD_MAX);
    if (q < CMD_MIN) q = longint'(CMD_MIN);
    res.cmd  = q[CMD_W-1:0];
    res.hold = 1'b1;
    return res;
  endfunction

  // Next heading: half the time a small step from the last one, else anywhere.
  function automatic logic signed [HEAD_W-1:0] pick_heading(
      input logic signed [HEAD_W-1:0] last);
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return HEAD_W'(last + $signed($urandom_range(128)) - 64);
    if (pick < 9) return HEAD_W'($urandom_range(5759) - 2880);
    return HEAD_W'($urandom);
  endfunction

  // Offer one word, wait for it to be taken, and record what it should yield.
  task automatic send_word(input stim_row_t row);
    yaw_word_t want;
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 10) begin
      in_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid              = 1'b1;
    in_bus.measured_heading   = row.heading;
    in_bus.rotation_commanded = row.rotate;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    want = pid_tick(row.heading, row.rotate);
    if (row.typed) want = row.typed_word;
    pending_cmds.push_back(want);
  endtask

  // Stop offering words and wait until every command has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    case (idx)
      REG_GAIN_P: m_gain_p = val;
      REG_GAIN_I: m_gain_i = val;
      REG_GAIN_D: m_gain_d = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_gains(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                           input logic [GAIN_W-1:0] gd);
    wait_drained();
    write_gain(REG_GAIN_P, gp);
    write_gain(REG_GAIN_I, gi);
    write_gain(REG_GAIN_D, gd);
  endtask

  // Random traffic: mostly rotation bursts followed by hold runs, some noise.
  task automatic run_phase(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                           input logic [GAIN_W-1:0] gd, input int n_words);
    stim_row_t                row;
    int                       sent;
    logic signed [HEAD_W-1:0] walk;
    set_gains(gp, gi, gd);
    sent = 0;
    walk = '0;
    row  = '0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 85) begin
        repeat ($urandom_range(1, 3)) begin
          row.heading = HEAD_W'($urandom);
          row.rotate  = 1'b1;
          send_word(row);
          sent++;
        end
        repeat ($urandom_range(1, 40)) begin
          walk        = pick_heading(walk);
          row.heading = walk;
          row.rotate  = 1'b0;
          send_word(row);
          sent++;
        end
      end else begin
        row.heading = HEAD_W'($urandom);
        row.rotate  = 1'($urandom);
        send_word(row);
        sent++;
      end
    end
  endtask

  // Capture a setpoint, then hold a constant error over a long run so the
  // integral keeps growing, and a few random words after that.
  task automatic integral_sweep(input logic signed [HEAD_W-1:0] anchor,
                                input logic signed [HEAD_W-1:0] held_heading);
    stim_row_t row;
    row = '{anchor, 1'b1, 1'b0, '{16'sd0, 1'b0}};
    send_word(row);
    row.rotate = 1'b0;
    send_word(row);
    row.heading = held_heading;
    repeat (SWEEP_LEN) send_word(row);
    repeat (20) begin
      row.heading = pick_heading(held_heading);
      send_word(row);
    end
  endtask

  // Output side: random stalls, none while steady.
  always @(negedge clk_i) begin
    out_bus.ready = steady || ($urandom_range(99) >= 10);
  end

  // Compare each accepted command word with the oldest expectation.
  always @(posedge clk_i) begin
    yaw_word_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_cmds.size() == 0) begin
        $error("yaw command word with none expected: cmd %0d hold %0b",
               out_bus.yaw_rate_command, out_bus.hold_active);
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_bus.yaw_rate_command !== want.cmd) begin
          $error("yaw_rate_command: expected %0d, got %0d", want.cmd,
                 out_bus.yaw_rate_command);
          mismatches++;
        end
        if (out_bus.hold_active !== want.hold) begin
          $error("hold_active: expected %0b, got %0b", want.hold, out_bus.hold_active);
          mismatches++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_n                     = 1'b0;
    steady                    = 1'b0;
    mismatches                = 0;
    cfg_we                    = 1'b0;
    cfg_idx                   = '0;
    cfg_wdata                 = '0;
    in_bus.valid              = 1'b0;
    in_bus.measured_heading   = '0;
    in_bus.rotation_commanded = 1'b0;
    out_bus.ready             = 1'b0;
    m_gain_p                  = GAIN_P_RESET;
    m_gain_i                  = GAIN_I_RESET;
    m_gain_d                  = GAIN_D_RESET;
    m_setpoint                = '0;
    m_captured                = 1'b0;
    m_integ                   = '0;
    m_prev_err                = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // A write past the last register must leave the reset gains alone.
    write_gain(REG_SPARE, 16'hFFFF);
    for (int i = 0; i < N_DIRECTED; i++) send_word(directed_rows[i]);

    run_phase(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET, 150);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 150);

    // Long hold runs, with no idling on either side.
    set_gains(16'd0, 16'd1, 16'd0);
    steady = 1'b1;
    integral_sweep(13'sd2879, -13'sd1);
    integral_sweep(-13'sd2880, 13'sd0);
    steady = 1'b0;

    run_phase(16'd0, 16'd0, 16'd0, 80);
    run_phase(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom), 100);
    run_phase(GAIN_W'($urandom_range(8191)), GAIN_W'($urandom_range(8191)),
              GAIN_W'($urandom_range(8191)), 100);
    run_phase(GAIN_W'($urandom_range(8191)), GAIN_W'($urandom_range(255)),
              GAIN_W'($urandom_range(8191)), 60);
    run_phase(16'hFFFF, 16'd0, 16'hFFFF, 60);
    run_phase(16'd0, 16'hFFFF, 16'd0, 60);

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
